// ----- hw/rtl/lruk_pkg.sv -----
package lruk_pkg;

   localparam int PAGE_TAG_W = 32;
   localparam int LEN_W      = 5;
   localparam int THRESH_W   = 8;
   localparam int CAP_W      = 5;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY  = 4'd1;

   localparam logic [THRESH_W-1:0] THRESHOLD_RST = 8'd2;
   localparam logic [CAP_W-1:0]    CAPACITY_RST  = 5'd16;
   localparam logic [THRESH_W-1:0] HIT_COUNT_MAX = 8'hFF;
   localparam logic [THRESH_W-1:0] HIT_COUNT_NEW = 8'd1;

   typedef enum logic [1:0] {
      FOUND_MISS  = 2'd0,
      FOUND_HIST  = 2'd1,
      FOUND_CACHE = 2'd2
   } found_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_CACHE,
      ST_CACHE_MOVE,
      ST_SCAN_HIST,
      ST_HIST_HIT,
      ST_HIST_MISS,
      ST_HIST_TRIM,
      ST_CACHE_TRIM,
      ST_RESP
   } state_type;

endpackage

// ----- hw/rtl/lruk_if.sv -----
interface lruk_req_if;
   import lruk_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [PAGE_TAG_W-1:0] page_tag;

   modport source (output valid, output page_tag, input ready);
   modport sink   (input valid, input page_tag, output ready);
endinterface

interface lruk_rsp_if;
   import lruk_pkg::*;

   logic                  valid;
   logic                  ready;
   found_type             found_where;
   logic                  promoted;
   logic                  history_evict_valid;
   logic [PAGE_TAG_W-1:0] history_evicted_tag;
   logic                  cache_evict_valid;
   logic [PAGE_TAG_W-1:0] cache_evicted_tag;
   logic [LEN_W-1:0]      history_length;
   logic [LEN_W-1:0]      cache_length;

   modport source (output valid, output found_where, output promoted,
                   output history_evict_valid, output history_evicted_tag,
                   output cache_evict_valid, output cache_evicted_tag,
                   output history_length, output cache_length, input ready);
   modport sink   (input valid, input found_where, input promoted,
                   input history_evict_valid, input history_evicted_tag,
                   input cache_evict_valid, input cache_evicted_tag,
                   input history_length, input cache_length, output ready);
endinterface

interface lruk_csr_if;
   import lruk_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/lru_k_replacement_core.sv -----
// One tag comparator scans the cache queue and then the history queue one entry
// per cycle. A cache hit stops the scan and moves the entry to the cache tail;
// otherwise a history hit update, or an insert and history trim, precedes a cache
// trim. One access is handled at a time; the next one is taken the cycle after the
// result transfer. Reset clears both queue fills, the state machine and the
// configuration (threshold 2, capacity 16); no clearing pass is needed.
module lru_k_replacement_core #(
   parameter int MAX_ENTRIES = 16,
   parameter int TAG_BITS    = 32
) (
   input  logic              clock,
   input  logic              reset,
   lruk_req_if.sink          req_bus,
   lruk_rsp_if.source        rsp_bus,
   lruk_csr_if.sink          csr_bus
);
   import lruk_pkg::*;

   localparam int SLOTS = MAX_ENTRIES + 1;
   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 2);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   state_type             state_ff, state_in;
   logic [TAG_BITS-1:0]   tag_ff, tag_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic [IDX_W-1:0]      hit_ff, hit_in;

   logic [TAG_BITS-1:0]   h_tag_ff [SLOTS];
   logic [TAG_BITS-1:0]   h_tag_in [SLOTS];
   logic [THRESH_W-1:0]   h_cnt_ff [SLOTS];
   logic [THRESH_W-1:0]   h_cnt_in [SLOTS];
   logic [TAG_BITS-1:0]   c_tag_ff [SLOTS];
   logic [TAG_BITS-1:0]   c_tag_in [SLOTS];
   logic [CNT_W-1:0]      h_fill_ff, h_fill_in;
   logic [CNT_W-1:0]      c_fill_ff, c_fill_in;

   logic [THRESH_W-1:0]   thr_ff, thr_in;
   logic [CAP_W-1:0]      cap_ff, cap_in;

   found_type             found_ff, found_in;
   logic                  promoted_ff, promoted_in;
   logic                  hev_ff, hev_in;
   logic [TAG_BITS-1:0]   htag_ff, htag_in;
   logic                  cev_ff, cev_in;
   logic [TAG_BITS-1:0]   ctag_ff, ctag_in;

   logic                  req_xfer;
   logic                  rsp_xfer;
   logic                  csr_xfer;
   logic [TAG_BITS-1:0]   scan_tag;
   logic                  scan_match;
   logic                  c_in_range;
   logic                  h_in_range;
   logic [CNT_W-1:0]      hit_ext;
   logic [CNT_W-1:0]      c_last;
   logic [CNT_W-1:0]      h_last;
   logic [THRESH_W-1:0]   hit_cnt;
   logic [THRESH_W-1:0]   hit_inc;
   logic                  promote;
   logic [CMP_W-1:0]      cap_eff;
   logic                  h_over;
   logic                  c_over;

   assign req_xfer = req_bus.valid && req_bus.ready;
   assign rsp_xfer = rsp_bus.valid && rsp_bus.ready;
   assign csr_xfer = csr_bus.valid && csr_bus.ready;

   // The single comparator is shared by the cache scan and the history scan.
   assign scan_tag   = (state_ff == ST_SCAN_CACHE) ? c_tag_ff[idx_ff[IDX_W-1:0]]
                                                   : h_tag_ff[idx_ff[IDX_W-1:0]];
   assign scan_match = (scan_tag == tag_ff);
   assign c_in_range = (idx_ff < c_fill_ff);
   assign h_in_range = (idx_ff < h_fill_ff);

   assign hit_ext = CNT_W'(hit_ff);
   assign c_last  = c_fill_ff - 1'b1;
   assign h_last  = h_fill_ff - 1'b1;
   assign hit_cnt = h_cnt_ff[hit_ff];
   assign hit_inc = (hit_cnt == HIT_COUNT_MAX) ? hit_cnt : hit_cnt + 1'b1;
   assign promote = (hit_inc >= thr_ff);

   assign cap_eff = (CMP_W'(cap_ff) > CMP_W'(MAX_ENTRIES)) ? CMP_W'(MAX_ENTRIES)
                                                            : CMP_W'(cap_ff);
   assign h_over  = (CMP_W'(h_fill_ff) > cap_eff);
   assign c_over  = (CMP_W'(c_fill_ff) > cap_eff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) state_in = ST_SCAN_CACHE;
         end
         ST_SCAN_CACHE: begin
            if (!c_in_range) state_in = ST_SCAN_HIST;
            else if (scan_match) state_in = ST_CACHE_MOVE;
         end
         ST_CACHE_MOVE: state_in = ST_RESP;
         ST_SCAN_HIST: begin
            if (!h_in_range) state_in = ST_HIST_MISS;
            else if (scan_match) state_in = ST_HIST_HIT;
         end
         ST_HIST_HIT:   state_in = ST_CACHE_TRIM;
         ST_HIST_MISS:  state_in = ST_HIST_TRIM;
         ST_HIST_TRIM:  state_in = ST_CACHE_TRIM;
         ST_CACHE_TRIM: state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_xfer) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_bus.ready = (state_ff == ST_IDLE);
      rsp_bus.valid = (state_ff == ST_RESP);
      csr_bus.ready = 1'b1;
   end

   assign rsp_bus.found_where         = found_ff;
   assign rsp_bus.promoted            = promoted_ff;
   assign rsp_bus.history_evict_valid = hev_ff;
   assign rsp_bus.history_evicted_tag = PAGE_TAG_W'(htag_ff);
   assign rsp_bus.cache_evict_valid   = cev_ff;
   assign rsp_bus.cache_evicted_tag   = PAGE_TAG_W'(ctag_ff);
   assign rsp_bus.history_length      = LEN_W'(h_fill_ff);
   assign rsp_bus.cache_length        = LEN_W'(c_fill_ff);

   always_comb begin
      thr_in = thr_ff;
      cap_in = cap_ff;
      if (csr_xfer) begin
         priority if (csr_bus.index == CSR_THRESHOLD) begin
            thr_in = THRESH_W'(csr_bus.data);
         end else if (csr_bus.index == CSR_CAPACITY) begin
            cap_in = CAP_W'(csr_bus.data);
         end
      end
   end

   always_comb begin
      tag_in      = tag_ff;
      idx_in      = idx_ff;
      hit_in      = hit_ff;
      h_tag_in    = h_tag_ff;
      h_cnt_in    = h_cnt_ff;
      c_tag_in    = c_tag_ff;
      h_fill_in   = h_fill_ff;
      c_fill_in   = c_fill_ff;
      found_in    = found_ff;
      promoted_in = promoted_ff;
      hev_in      = hev_ff;
      htag_in     = htag_ff;
      cev_in      = cev_ff;
      ctag_in     = ctag_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               tag_in      = TAG_BITS'(req_bus.page_tag);
               idx_in      = '0;
               found_in    = FOUND_MISS;
               promoted_in = 1'b0;
               hev_in      = 1'b0;
               htag_in     = '0;
               cev_in      = 1'b0;
               ctag_in     = '0;
            end
         end
         ST_SCAN_CACHE: begin
            if (!c_in_range) begin
               idx_in = '0;
            end else if (scan_match) begin
               hit_in = idx_ff[IDX_W-1:0];
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_SCAN_HIST: begin
            if (h_in_range) begin
               if (scan_match) hit_in = idx_ff[IDX_W-1:0];
               else idx_in = idx_ff + 1'b1;
            end
         end
         ST_CACHE_MOVE: begin
            found_in = FOUND_CACHE;
            for (int j = 0; j < SLOTS - 1; j++) begin
               if (CNT_W'(j) >= hit_ext && CNT_W'(j) < c_last) begin
                  c_tag_in[j] = c_tag_ff[j+1];
               end
            end
            c_tag_in[c_last[IDX_W-1:0]] = tag_ff;
         end
         ST_HIST_HIT: begin
            found_in = FOUND_HIST;
            for (int j = 0; j < SLOTS - 1; j++) begin
               if (CNT_W'(j) >= hit_ext && CNT_W'(j) < h_last) begin
                  h_tag_in[j] = h_tag_ff[j+1];
                  h_cnt_in[j] = h_cnt_ff[j+1];
               end
            end
            if (promote) begin
               promoted_in = 1'b1;
               h_fill_in   = h_last;
               c_tag_in[c_fill_ff[IDX_W-1:0]] = tag_ff;
               c_fill_in   = c_fill_ff + 1'b1;
            end else begin
               h_tag_in[h_last[IDX_W-1:0]] = tag_ff;
               h_cnt_in[h_last[IDX_W-1:0]] = hit_inc;
            end
         end
         ST_HIST_MISS: begin
            h_tag_in[h_fill_ff[IDX_W-1:0]] = tag_ff;
            h_cnt_in[h_fill_ff[IDX_W-1:0]] = HIT_COUNT_NEW;
            h_fill_in = h_fill_ff + 1'b1;
         end
         ST_HIST_TRIM: begin
            if (h_over) begin
               hev_in  = 1'b1;
               htag_in = h_tag_ff[0];
               for (int j = 0; j < SLOTS - 1; j++) begin
                  h_tag_in[j] = h_tag_ff[j+1];
                  h_cnt_in[j] = h_cnt_ff[j+1];
               end
               h_fill_in = h_last;
            end
         end
         ST_CACHE_TRIM: begin
            if (c_over) begin
               cev_in  = 1'b1;
               ctag_in = c_tag_ff[0];
               for (int j = 0; j < SLOTS - 1; j++) begin
                  c_tag_in[j] = c_tag_ff[j+1];
               end
               c_fill_in = c_last;
            end
         end
         ST_RESP: begin
            idx_in = idx_ff;
         end
         default: begin
            idx_in = idx_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         h_fill_ff <= '0;
         c_fill_ff <= '0;
         thr_ff    <= THRESHOLD_RST;
         cap_ff    <= CAPACITY_RST;
      end else begin
         state_ff  <= state_in;
         h_fill_ff <= h_fill_in;
         c_fill_ff <= c_fill_in;
         thr_ff    <= thr_in;
         cap_ff    <= cap_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff      <= tag_in;
      idx_ff      <= idx_in;
      hit_ff      <= hit_in;
      h_tag_ff    <= h_tag_in;
      h_cnt_ff    <= h_cnt_in;
      c_tag_ff    <= c_tag_in;
      found_ff    <= found_in;
      promoted_ff <= promoted_in;
      hev_ff      <= hev_in;
      htag_ff     <= htag_in;
      cev_ff      <= cev_in;
      ctag_ff     <= ctag_in;
   end

`ifndef SYNTH
   a_idle_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_RESP) |->
         (h_fill_ff <= CNT_W'(MAX_ENTRIES) && c_fill_ff <= CNT_W'(MAX_ENTRIES)))
      else $error("queue fill exceeds the entry count between accesses");

   a_ready_valid_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_bus.ready && rsp_bus.valid))
      else $error("request ready while a result is pending");

   a_accept_scans: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == ST_SCAN_CACHE))
      else $error("accepted access did not start the cache scan");

   a_cache_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.found_where == FOUND_CACHE) |->
         (!rsp_bus.cache_evict_valid && !rsp_bus.history_evict_valid &&
          !rsp_bus.promoted))
      else $error("cache hit reported an eviction or a promotion");
`endif

endmodule
